### hdl/fp10_format_converter_macros.svh
// Assertion macros for the port-level checker
`ifndef FP10_FORMAT_CONVERTER_MACROS_SVH
`define FP10_FORMAT_CONVERTER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define FPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fpc_pkg.sv
// Shared types, codes and constants for the fp10 converter
package fpc_pkg;

    typedef enum logic [1:0] {
        OP_INT_TO_FP10   = 2'd0,
        OP_FP10_TO_INT   = 2'd1,
        OP_FLOAT_TO_FP10 = 2'd2,
        OP_FP10_TO_FLOAT = 2'd3
    } op_t;

    localparam logic [15:0] FP10_NEG_BITS = 16'hFE00;
    localparam logic [15:0] FP10_INF      = 16'h01F0;
    localparam logic [15:0] FP10_NAN      = 16'h01F1;
    localparam logic [31:0] INT_INVALID   = 32'h8000_0000;
    localparam logic [31:0] F32_INF       = 32'h7F80_0000;
    localparam logic [31:0] F32_NAN       = 32'h7F80_0001;

    typedef struct packed {
        op_t         op;
        logic [31:0] operand;
    } fpc_item_t;

endpackage

### hdl/fpc_convert.sv
// Combinational conversion datapath for all four operations
module fpc_convert
    import fpc_pkg::*;
(
    input  fpc_item_t   item,
    output logic [31:0] result
);

    // Round (mag >> sh) to nearest even; sh in 1..31
    function automatic logic [31:0] round_shift(input logic [31:0] mag, input logic [4:0] sh);
        logic [31:0] q;
        logic [31:0] mask;
        logic [31:0] half;
        logic [31:0] rem;
        q    = mag >> sh;
        mask = (32'd1 << sh) - 32'd1;
        half = 32'd1 << (sh - 5'd1);
        rem  = mag & mask;
        if (rem > half || (rem == half && q[0]))
            q = q + 32'd1;
        return q;
    endfunction

    logic [31:0] v;
    assign v = item.operand;

    // ---------- int32 -> fp10
    logic        i_neg;
    logic [31:0] i_mag;
    logic [4:0]  i_lead;
    logic [31:0] i_q;
    logic [5:0]  i_exp;
    logic [3:0]  i_frac;
    logic [15:0] i_res;

    always_comb
    begin
        i_neg  = v[31];
        i_mag  = i_neg ? (32'd0 - v) : v;
        i_lead = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (i_mag[k])
                i_lead = 5'(k);
        end
        i_q    = '0;
        i_exp  = 6'(i_lead) + 6'd15;
        i_frac = '0;
        if (i_lead > 5'd4)
        begin
            i_q = round_shift(i_mag, i_lead - 5'd4);
            if (i_q == 32'd32)
                i_exp = i_exp + 6'd1;
            i_frac = i_q[3:0];
        end
        else
        begin
            i_frac = 4'((i_mag & ~(32'd1 << i_lead)) << (5'd4 - i_lead));
        end
        if (i_mag == '0)
            i_res = '0;
        else if (i_exp >= 6'd31)
            i_res = (i_neg ? FP10_NEG_BITS : 16'd0) | FP10_INF;
        else
            i_res = (i_neg ? FP10_NEG_BITS : 16'd0) | {7'd0, i_exp[4:0], i_frac};
    end

    // ---------- fp10 -> int32
    logic [4:0]  h_exp;
    logic [31:0] h_mag;
    logic [31:0] h_res;

    always_comb
    begin
        h_exp = v[8:4];
        h_mag = {27'd0, 1'b1, v[3:0]};
        if (h_exp > 5'd19)
            h_mag = h_mag << (h_exp - 5'd19);
        else
            h_mag = h_mag >> (5'd19 - h_exp);
        if (h_exp == 5'd0)
            h_res = '0;
        else if (h_exp == 5'd31)
            h_res = INT_INVALID;
        else
            h_res = v[15] ? (32'd0 - h_mag) : h_mag;
    end

    // ---------- binary32 -> fp10
    logic [15:0] f_sgn;
    logic [7:0]  f_be;
    logic [31:0] f_mant;
    logic [9:0]  f_te;
    logic [9:0]  f_sh;
    logic [31:0] f_q;
    logic [9:0]  f_te2;
    logic [15:0] f_res;

    always_comb
    begin
        f_sgn  = v[31] ? FP10_NEG_BITS : 16'd0;
        f_be   = v[30:23];
        f_mant = {8'd0, 1'b1, v[22:0]};
        f_te   = 10'(f_be) - 10'd112;
        f_sh   = 10'd20 - f_te;
        f_q    = '0;
        f_te2  = f_te;
        f_res  = f_sgn;
        if (f_be == 8'hFF)
            f_res = f_sgn | ((v[22:0] != '0) ? FP10_NAN : FP10_INF);
        else if (f_be == 8'd0)
            f_res = f_sgn;
        else if (!f_te[9] && f_te != 10'd0)
        begin
            f_q = round_shift(f_mant, 5'd19);
            if (f_q == 32'd32)
                f_te2 = f_te + 10'd1;
            if (f_te2 >= 10'd31)
                f_res = f_sgn | FP10_INF;
            else
                f_res = f_sgn | {7'd0, f_te2[4:0], f_q[3:0]};
        end
        else if (f_sh >= 10'd26)
            f_res = f_sgn;
        else
        begin
            f_q   = round_shift(f_mant, f_sh[4:0]);
            f_res = f_sgn | f_q[15:0];
        end
    end

    // ---------- fp10 -> binary32
    logic [31:0] g_sgn;
    logic [4:0]  g_exp;
    logic [3:0]  g_fr;
    logic [1:0]  g_lead;
    logic [31:0] g_res;

    always_comb
    begin
        g_sgn  = {v[15], 31'd0};
        g_exp  = v[8:4];
        g_fr   = v[3:0];
        g_lead = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (g_fr[k])
                g_lead = 2'(k);
        end
        if (g_exp == 5'd31)
            g_res = g_sgn | ((g_fr != '0) ? F32_NAN : F32_INF);
        else if (g_exp != 5'd0)
            g_res = g_sgn | {1'b0, 8'(g_exp) + 8'd112, g_fr, 19'd0};
        else if (g_fr == '0)
            g_res = g_sgn;
        else
            g_res = g_sgn | {1'b0, 8'd109 + 8'(g_lead),
                23'({19'd0, g_fr & ~(4'd1 << g_lead)} << (5'd23 - 5'(g_lead)))};
    end

    always_comb
    begin
        unique case (item.op)
            OP_INT_TO_FP10:   result = {16'd0, i_res};
            OP_FP10_TO_INT:   result = h_res;
            OP_FLOAT_TO_FP10: result = {16'd0, f_res};
            OP_FP10_TO_FLOAT: result = g_res;
            default:          result = g_res;
        endcase
    end

endmodule

### hdl/fp10_format_converter.sv
// Top level: input register, conversion logic, output register
//
//  channel | handshake                 | payload
//  in      | in_valid / in_ready       | operation[1:0], operand[31:0]
//  out     | out_valid / out_ready     | converted[31:0]
//
// One transaction per cycle while out_ready does not stall the output.
// The rate is set by the two-register pipeline: input stage, then result stage.
// Reset clears both valid flags; payload registers are not reset.
// A stall downstream propagates back one stage at a time; in_ready is high
// whenever the input stage is empty or moving forward.
module fp10_format_converter
    import fpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] operand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] converted
);

    fpc_item_t   item_reg;
    logic        item_vld_reg;
    logic [31:0] res_reg;
    logic        res_vld_reg;
    logic [31:0] res_next;
    logic        adv;

    fpc_convert u_convert (
        .item   (item_reg),
        .result (res_next)
    );

    assign adv      = !res_vld_reg || out_ready;
    assign in_ready = !item_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_vld_reg <= in_valid;
            if (adv)
                res_vld_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{op: op_t'(operation), operand: operand};
        if (adv && item_vld_reg)
            res_reg <= res_next;
    end

    assign out_valid = res_vld_reg;
    assign converted = res_reg;

endmodule

### hdl/fpc_checker.sv
// Port-level checker for the converter, bound to the top level
`include "fp10_format_converter_macros.svh"

module fpc_checker
    import fpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  operation,
    input logic [31:0] operand,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] converted
);

    // offered input payload is fully known
    `FPC_ASSERT_IMP(a_in_known, clk, rst_n, in_valid,
        !$isunknown({operation, operand}), "unknown input payload")
    // presented result is fully known
    `FPC_ASSERT_IMP(a_out_known, clk, rst_n, out_valid,
        !$isunknown(converted), "unknown result")
    // a stalled result holds
    `FPC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(converted), "result changed while stalled")
    // when output is free, input is ready
    `FPC_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind fp10_format_converter fpc_checker u_fpc_checker (.*);

### verif/tb_fp10_format_converter.sv
// Testbench for the fp10 format converter: directed and random conversions with a scoreboard
module tb_fp10_format_converter;
    import fpc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_INT_TO_FP10;
    logic [31:0] operand = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] converted;

    fp10_format_converter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .operand(operand),
        .out_valid(out_valid), .out_ready(out_ready),
        .converted(converted)
    );

    always #5 clk = ~clk;

    fpc_item_t   pending_ops[$];
    logic [31:0] expected_conv[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          stim_done = 0;
    int          mismatches = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          op_count[4] = '{0, 0, 0, 0};

    // round mag >> sh to nearest even, 1 <= sh <= 31
    function automatic logic [31:0] rne_shift(logic [31:0] mag, int sh);
        logic [31:0] q, rem, half;
        q = mag >> sh;
        rem = mag & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 32'd1;
        return q;
    endfunction

    function automatic logic [31:0] conv_int(logic [31:0] v);
        logic [31:0] mag, q, frac, sgn;
        int lead, e;
        mag = v[31] ? -v : v;
        sgn = v[31] ? 32'(FP10_NEG_BITS) : 32'd0;
        lead = 0;
        if (mag == 0)
            return 32'd0;
        for (int k = 0; k < 32; k++)
            if (mag[k])
                lead = k;
        if (lead > 4)
        begin
            q = rne_shift(mag, lead - 4);
            if (q == 32)
            begin
                q = 16;
                lead++;
            end
            frac = q & 32'hF;
        end
        else
            frac = (mag & ~(32'd1 << lead)) << (4 - lead);
        e = lead + 15;
        if (e >= 31)
            return sgn | 32'(FP10_INF);
        return sgn | (32'(e) << 4) | frac;
    endfunction

    function automatic logic [31:0] conv_to_int(logic [31:0] x);
        logic [31:0] e, m, r;
        e = (x >> 4) & 32'h1F;
        m = 32'h10 | (x & 32'hF);
        if (e == 0)
            return 32'd0;
        if (e == 31)
            return INT_INVALID;
        r = (e > 19) ? (m << (e - 19)) : (m >> (19 - e));
        return x[15] ? -r : r;
    endfunction

    function automatic logic [31:0] conv_float(logic [31:0] f);
        logic [31:0] sgn, mant, q;
        int be, te;
        sgn = f[31] ? 32'(FP10_NEG_BITS) : 32'd0;
        be = int'(f[30:23]);
        if (be == 255)
            return sgn | ((f[22:0] != 0) ? 32'(FP10_NAN) : 32'(FP10_INF));
        if (be == 0)
            return sgn;
        mant = {9'd1, f[22:0]};
        te = be - 112;
        if (te >= 1)
        begin
            if (te >= 31)
                return sgn | 32'(FP10_INF);
            q = rne_shift(mant, 19);
            if (q == 32)
            begin
                q = 16;
                te++;
            end
            if (te >= 31)
                return sgn | 32'(FP10_INF);
            return sgn | (32'(te) << 4) | (q & 32'hF);
        end
        if (20 - te >= 26)
            return sgn;
        return sgn | rne_shift(mant, 20 - te);
    endfunction

    function automatic logic [31:0] conv_to_float(logic [31:0] x);
        logic [31:0] sgn, e, fr;
        int lead;
        sgn = {x[15], 31'd0};
        e = (x >> 4) & 32'h1F;
        fr = x & 32'hF;
        lead = 0;
        if (e == 31)
            return sgn | ((fr != 0) ? F32_NAN : F32_INF);
        if (e != 0)
            return sgn | ((e + 112) << 23) | (fr << 19);
        if (fr == 0)
            return sgn;
        for (int k = 0; k < 4; k++)
            if (fr[k])
                lead = k;
        return sgn | (32'(109 + lead) << 23) | ((fr & ~(32'd1 << lead)) << (23 - lead));
    endfunction

    function automatic logic [31:0] predict_conversion(fpc_item_t it);
        logic [31:0] r;
        case (it.op)
            OP_INT_TO_FP10:   r = conv_int(it.operand) & 32'hFFFF;
            OP_FP10_TO_INT:   r = conv_to_int(it.operand);
            OP_FLOAT_TO_FP10: r = conv_float(it.operand) & 32'hFFFF;
            default:          r = conv_to_float(it.operand);
        endcase
        return r;
    endfunction

    task automatic queue_op(op_t op, logic [31:0] val);
        fpc_item_t it;
        it.op = op;
        it.operand = val;
        pending_ops.push_back(it);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (in_valid)
                begin
                    expected_conv.push_back(predict_conversion('{op_t'(operation), operand}));
                    n_sent++;
                    op_count[operation]++;
                end
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    fpc_item_t it;
                    it = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    operation <= it.op;
                    operand <= it.operand;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_conv.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: converted=%h", converted);
            end
            else
            begin
                logic [31:0] exp_v;
                exp_v = expected_conv.pop_front();
                n_checked++;
                if (converted !== exp_v)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_v, converted);
                end
            end
        end
    end

    // check just after the edge so the driver's updates have settled
    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_ops.size() > 0 || in_valid || expected_conv.size() > 0);
    endtask

    task automatic random_batch(int n);
        logic [31:0] v;
        op_t op;
        for (int k = 0; k < n; k++)
        begin
            op = op_t'($urandom_range(3));
            v = $urandom();
            case ($urandom_range(3))
                0: v = v >> $urandom_range(31);
                1: if (op == OP_FLOAT_TO_FP10)
                       v = {v[31], 8'($urandom_range(88, 145)), v[22:0]};
                2: if (op == OP_FP10_TO_INT || op == OP_FP10_TO_FLOAT)
                       v = {{16{v[15]}}, v[15:0]};
                default: ;
            endcase
            queue_op(op, v);
        end
    endtask

    initial
    begin
        // directed: extremes and special cases
        queue_op(OP_INT_TO_FP10, 32'd0);
        queue_op(OP_INT_TO_FP10, 32'd1);
        queue_op(OP_INT_TO_FP10, 32'hFFFF_FFFF);
        queue_op(OP_INT_TO_FP10, 32'h8000_0000);
        queue_op(OP_INT_TO_FP10, 32'h7FFF_FFFF);
        queue_op(OP_INT_TO_FP10, 32'd62);          // all fraction bits set, no rounding
        queue_op(OP_INT_TO_FP10, 32'hFFFF);        // exponent limit
        queue_op(OP_INT_TO_FP10, 32'd34);          // exact, no rounding
        queue_op(OP_FP10_TO_INT, 32'h0000_000F);   // subnormal
        queue_op(OP_FP10_TO_INT, 32'h0000_01F0);
        queue_op(OP_FP10_TO_INT, 32'hFFFF_FFF3);   // negative NaN
        queue_op(OP_FP10_TO_INT, 32'h0000_81EF);
        queue_op(OP_FP10_TO_INT, 32'h0000_7E35);   // junk in sign copies
        queue_op(OP_FLOAT_TO_FP10, 32'h7FC0_0000);
        queue_op(OP_FLOAT_TO_FP10, 32'hFF80_0000);
        queue_op(OP_FLOAT_TO_FP10, 32'h8000_0001);
        queue_op(OP_FLOAT_TO_FP10, 32'h477C_0000); // rounds to infinity
        queue_op(OP_FLOAT_TO_FP10, 32'h3600_0001); // subnormal with sticky
        queue_op(OP_FLOAT_TO_FP10, 32'h3380_0000); // flushed to zero
        queue_op(OP_FLOAT_TO_FP10, 32'h387C_0000); // subnormal carry to normal
        queue_op(OP_FP10_TO_FLOAT, 32'h0000_0001);
        queue_op(OP_FP10_TO_FLOAT, 32'h0000_8000);
        queue_op(OP_FP10_TO_FLOAT, 32'h0000_81F0);
        queue_op(OP_FP10_TO_FLOAT, 32'hFFFF_01F9);
        queue_op(OP_FP10_TO_FLOAT, 32'h0000_01EF);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        drain();
        random_batch(100);
        drain();
        send_idle_pct = 78;
        random_batch(100);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 78;
        random_batch(100);
        drain();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        random_batch(100);
        drain();
        repeat (10) @(posedge clk);
        $display("checked %0d of %0d transactions (ops %0d/%0d/%0d/%0d) over four idle phases",
                 n_checked, n_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        if (mismatches == 0 && expected_conv.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/fpc_pkg.sv
hdl/fpc_convert.sv
hdl/fp10_format_converter.sv
hdl/fpc_checker.sv
verif/tb_fp10_format_converter.sv
